// ===== src/stc_pkg.sv =====
package stc_pkg;

   // field and port widths
   localparam int FreqW    = 24;
   localparam int RatioW   = 17;
   localparam int DirW     = 2;
   localparam int StatusW  = 2;
   localparam int VelW     = 15;
   localparam int ReqDataW = 56;
   localparam int RspDataW = 16;
   localparam int CsrIdxW  = 1;

   // digit-serial multiplier: MulAW x MulBW, DigitW bits of b per step
   localparam int MulAW    = 40;
   localparam int MulBW    = 24;
   localparam int DigitW   = 8;
   localparam int MulSteps = MulBW / DigitW;
   localparam int MulCntW  = $clog2(MulSteps);
   localparam int MulPW    = MulAW + MulBW;

   // datapath widths
   localparam int BandW = RatioW + FreqW;   // ratio times target
   localparam int MW    = 18;               // saturated angle, Q0.20
   localparam int UW    = 41;               // A*m - B*2^20, two's complement
   localparam int SW    = 58;               // Q48 sum, two's complement
   localparam int RW    = 18;               // rounded Q8.8 before clamping
   localparam int MSh   = 24;
   localparam int BSh   = 20;
   localparam int QSh   = 40;

   // reciprocal calibration slopes, Q0.32
   localparam logic [FreqW-1:0] KCw  = FreqW'(16377065);
   localparam logic [FreqW-1:0] KCcw = FreqW'(15795547);
   localparam logic [FreqW-1:0] KAvg = FreqW'(16086306);

   localparam logic [MW-1:0] MPosMax = MW'(83886);
   localparam logic [MW-1:0] MNegMax = MW'(146801);

   localparam logic [MulAW-1:0] APos = MulAW'(1166200);
   localparam logic [MulAW-1:0] ANeg = MulAW'(193416);
   localparam logic [UW-1:0]    BPosQ = UW'(218906) << BSh;
   localparam logic [UW-1:0]    BNegQ = UW'(97367) << BSh;
   localparam logic [SW-1:0]    CPosQ = SW'(5273) << QSh;
   localparam logic [SW-1:0]    CNegQ = SW'(4360) << QSh;

   localparam logic [SW-1:0] RoundHalf     = SW'(1) << (QSh - 1);
   localparam logic [SW-1:0] RoundHalfLess = RoundHalf - SW'(1);
   localparam logic [2*MSh-1:0] MRoundHalf = (2*MSh)'(1) << (MSh - 1);

   localparam logic signed [RW-1:0] VPosLo = RW'(11520);
   localparam logic signed [RW-1:0] VPosHi = RW'(15360);
   localparam logic signed [RW-1:0] VNegLo = RW'(-14080);
   localparam logic signed [RW-1:0] VNegHi = RW'(-6400);

   // direction codes
   localparam logic [DirW-1:0] DirNone = 2'd0;
   localparam logic [DirW-1:0] DirPos  = 2'd1;
   localparam logic [DirW-1:0] DirNeg  = 2'd3;

   // status codes
   localparam logic [StatusW-1:0] StatInTarget = 2'd0;
   localparam logic [StatusW-1:0] StatEngage   = 2'd1;
   localparam logic [StatusW-1:0] StatRecorded = 2'd2;
   localparam logic [StatusW-1:0] StatFailed   = 2'd3;

   // request kinds
   localparam logic ReqTune   = 1'b0;
   localparam logic ReqReport = 1'b1;

   // register indexes
   localparam logic [CsrIdxW-1:0] CsrTolHigh = 1'b0;
   localparam logic [CsrIdxW-1:0] CsrTolLow  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOW,
      ST_HIGH,
      ST_DK,
      ST_AM,
      ST_UM_GO,
      ST_UM,
      ST_ROUND,
      ST_CLAMP,
      ST_EMIT
   } stc_state_type;

endpackage

// ===== src/stc_mul.sv =====
// unsigned shift-add multiplier, one digit of b per cycle, low digit first
module stc_mul (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [stc_pkg::MulAW-1:0]   a,
   input  logic [stc_pkg::MulBW-1:0]   b,
   output logic                        done,
   output logic [stc_pkg::MulPW-1:0]   prod
);

   localparam int SumW = stc_pkg::MulAW + stc_pkg::DigitW;

   logic [stc_pkg::MulAW-1:0]   a_ff, a_in;
   logic [stc_pkg::MulAW-1:0]   hi_ff, hi_in;
   logic [stc_pkg::MulBW-1:0]   lo_ff, lo_in;
   logic [stc_pkg::MulCntW-1:0] cnt_ff, cnt_in;
   logic                        busy_ff, busy_in;
   logic                        done_ff, done_in;
   logic [SumW-1:0]             step_sum;

   assign step_sum = SumW'(hi_ff)
                   + SumW'(a_ff) * SumW'(lo_ff[stc_pkg::DigitW-1:0]);

   always_comb begin
      a_in    = a_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         hi_in   = '0;
         lo_in   = b;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // low product bits retire into the top of the b shift register
         hi_in  = step_sum[SumW-1:stc_pkg::DigitW];
         lo_in  = {step_sum[stc_pkg::DigitW-1:0],
                   lo_ff[stc_pkg::MulBW-1:stc_pkg::DigitW]};
         cnt_in = cnt_ff + stc_pkg::MulCntW'(1);
         if (cnt_ff == stc_pkg::MulCntW'(stc_pkg::MulSteps - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff  <= a_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign done = done_ff;
   assign prod = {hi_ff, lo_ff};

endmodule

// ===== src/string_tuning_impact_controller_top.sv =====
// Requests are handled one at a time: req_tready is high only while the sequencer is idle.
// An impact report goes straight to emit; a tune request passes through the shared
// 8-bit-digit multiplier for the lower and upper band products, and one that engages
// makes five passes, then rounding and clamping. Emit waits for a free output register.
// Reset (synchronous, active high): tolerance registers to defaults, both directions to
// none, sequencer idle, output empty.
module string_tuning_impact_controller_top (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [23:0] target_freq, [47:24] current_freq, [48] impact_ok, rest zero
   input  logic [stc_pkg::ReqDataW-1:0]  req_tdata,
   // [0] req_type
   input  logic [0:0]                    req_tuser,
   // result channel
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [14:0] velocity, [15] zero
   output logic [stc_pkg::RspDataW-1:0]  rsp_tdata,
   // [1:0] status
   output logic [stc_pkg::StatusW-1:0]   rsp_tuser,
   // configuration write port
   input  logic                          csr_wr_en,
   input  logic [stc_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [stc_pkg::RatioW-1:0]    csr_wdata
);

   // ---------------------------------------------------------------------------
   // request fields straight off the bus
   // ---------------------------------------------------------------------------
   logic [stc_pkg::FreqW-1:0] req_tf;
   logic [stc_pkg::FreqW-1:0] req_cf;
   logic                      req_ok;
   logic                      req_kind;

   assign req_tf   = req_tdata[stc_pkg::FreqW-1:0];
   assign req_cf   = req_tdata[2*stc_pkg::FreqW-1:stc_pkg::FreqW];
   assign req_ok   = req_tdata[2*stc_pkg::FreqW];
   assign req_kind = req_tuser[0];

   // ---------------------------------------------------------------------------
   // state
   // ---------------------------------------------------------------------------
   stc_pkg::stc_state_type state_ff, state_in;

   logic [stc_pkg::RatioW-1:0]  tol_high_ff, tol_high_in;
   logic [stc_pkg::RatioW-1:0]  tol_low_ff, tol_low_in;
   logic [stc_pkg::DirW-1:0]    last_dir_ff, last_dir_in;
   logic [stc_pkg::DirW-1:0]    pend_dir_ff, pend_dir_in;
   logic                        rsp_tvalid_ff, rsp_tvalid_in;

   // working registers of the item in flight
   logic [stc_pkg::FreqW-1:0]   cf_ff, cf_in;
   logic [stc_pkg::FreqW-1:0]   tf_ff, tf_in;
   logic [stc_pkg::FreqW-1:0]   d_ff, d_in;
   logic                        up_ff, up_in;
   logic                        low_ok_ff, low_ok_in;
   logic [stc_pkg::MW-1:0]      m_ff, m_in;
   logic [stc_pkg::UW-1:0]      u_ff, u_in;
   logic [stc_pkg::SW-1:0]      w_ff, w_in;
   logic [stc_pkg::RW-1:0]      r_ff, r_in;
   logic [stc_pkg::StatusW-1:0] res_status_ff, res_status_in;
   logic [stc_pkg::VelW-1:0]    res_vel_ff, res_vel_in;
   logic [stc_pkg::StatusW-1:0] rsp_status_ff, rsp_status_in;
   logic [stc_pkg::VelW-1:0]    rsp_vel_ff, rsp_vel_in;

   // ---------------------------------------------------------------------------
   // shared multiplier
   // ---------------------------------------------------------------------------
   logic                        mul_start;
   logic [stc_pkg::MulAW-1:0]   mul_a;
   logic [stc_pkg::MulBW-1:0]   mul_b;
   logic                        mul_done;
   logic [stc_pkg::MulPW-1:0]   mul_prod;

   stc_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   // ---------------------------------------------------------------------------
   // datapath helpers
   // ---------------------------------------------------------------------------
   logic                          req_xfer;
   logic                          out_free;
   logic [stc_pkg::BandW-1:0]     scaled;
   logic                          in_band;
   logic [stc_pkg::FreqW-1:0]     k_sel;
   logic [2*stc_pkg::MSh:0]       m_sum;
   logic [stc_pkg::MSh:0]         m_q;
   logic [stc_pkg::MW-1:0]        m_max;
   logic [stc_pkg::MW-1:0]        m_next;
   logic [stc_pkg::UW-1:0]        u_mag;
   logic [stc_pkg::UW-1:0]        b_q;
   logic [stc_pkg::SW-1:0]        c_q;
   logic [stc_pkg::SW-1:0]        p_q;
   logic [stc_pkg::SW-1:0]        rnd;
   logic signed [stc_pkg::RW-1:0] v_raw;
   logic signed [stc_pkg::RW-1:0] v_cl;

   assign req_xfer = req_tvalid && req_tready;
   // output register can take a result this cycle
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   // current * 2^16 against ratio * target
   assign scaled  = {1'b0, cf_ff, 16'b0};
   assign in_band = low_ok_ff && (scaled < mul_prod[stc_pkg::BandW-1:0]);

   always_comb begin
      if (last_dir_ff == stc_pkg::DirPos) begin
         k_sel = stc_pkg::KCw;
      end else if (last_dir_ff == stc_pkg::DirNeg) begin
         k_sel = stc_pkg::KCcw;
      end else begin
         k_sel = stc_pkg::KAvg;
      end
   end

   // angle magnitude: round half up of d*K / 2^24, then saturate
   assign m_sum  = {1'b0, mul_prod[2*stc_pkg::MSh-1:0]} + {1'b0, stc_pkg::MRoundHalf};
   assign m_q    = m_sum[2*stc_pkg::MSh:stc_pkg::MSh];
   assign m_max  = up_ff ? stc_pkg::MPosMax : stc_pkg::MNegMax;
   assign m_next = (m_q > (stc_pkg::MSh+1)'(m_max)) ? m_max : m_q[stc_pkg::MW-1:0];

   // quadratic folded as C*2^40 - m*(A*m - B*2^20); negative branch is its negation
   assign b_q   = up_ff ? stc_pkg::BPosQ : stc_pkg::BNegQ;
   assign c_q   = up_ff ? stc_pkg::CPosQ : stc_pkg::CNegQ;
   assign u_mag = u_ff[stc_pkg::UW-1] ? (~u_ff + stc_pkg::UW'(1)) : u_ff;
   assign p_q   = mul_prod[stc_pkg::SW-1:0];

   // ties away from zero: bias by half, or half less one for negatives, then floor
   assign rnd = w_ff + (w_ff[stc_pkg::SW-1] ? stc_pkg::RoundHalfLess : stc_pkg::RoundHalf);

   // symmetric rounding lets the negative branch negate after rounding
   assign v_raw = up_ff ? signed'(r_ff) : -signed'(r_ff);

   always_comb begin
      if (up_ff) begin
         if (v_raw < stc_pkg::VPosLo) begin
            v_cl = stc_pkg::VPosLo;
         end else if (v_raw > stc_pkg::VPosHi) begin
            v_cl = stc_pkg::VPosHi;
         end else begin
            v_cl = v_raw;
         end
      end else begin
         if (v_raw < stc_pkg::VNegLo) begin
            v_cl = stc_pkg::VNegLo;
         end else if (v_raw > stc_pkg::VNegHi) begin
            v_cl = stc_pkg::VNegHi;
         end else begin
            v_cl = v_raw;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // sequencer: next state
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         stc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = (req_kind == stc_pkg::ReqReport) ? stc_pkg::ST_EMIT
                                                          : stc_pkg::ST_LOW;
            end
         end
         stc_pkg::ST_LOW: begin
            if (mul_done) state_in = stc_pkg::ST_HIGH;
         end
         stc_pkg::ST_HIGH: begin
            if (mul_done) state_in = in_band ? stc_pkg::ST_EMIT : stc_pkg::ST_DK;
         end
         stc_pkg::ST_DK: begin
            if (mul_done) state_in = stc_pkg::ST_AM;
         end
         stc_pkg::ST_AM: begin
            if (mul_done) state_in = stc_pkg::ST_UM_GO;
         end
         stc_pkg::ST_UM_GO: begin
            state_in = stc_pkg::ST_UM;
         end
         stc_pkg::ST_UM: begin
            if (mul_done) state_in = stc_pkg::ST_ROUND;
         end
         stc_pkg::ST_ROUND: begin
            state_in = stc_pkg::ST_CLAMP;
         end
         stc_pkg::ST_CLAMP: begin
            state_in = stc_pkg::ST_EMIT;
         end
         stc_pkg::ST_EMIT: begin
            if (out_free) state_in = stc_pkg::ST_IDLE;
         end
         default: begin
            state_in = stc_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------------------------------------------------------------------
   // sequencer: outputs (handshake and multiplier operands)
   // ---------------------------------------------------------------------------
   always_comb begin
      req_tready = 1'b0;
      mul_start  = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      unique case (state_ff)
         stc_pkg::ST_IDLE: begin
            // lower band product starts in the accepting cycle
            req_tready = 1'b1;
            mul_start  = req_tvalid && (req_kind == stc_pkg::ReqTune);
            mul_a      = stc_pkg::MulAW'(req_tf);
            mul_b      = stc_pkg::MulBW'(tol_low_ff);
         end
         stc_pkg::ST_LOW: begin
            mul_start = mul_done;
            mul_a     = stc_pkg::MulAW'(tf_ff);
            mul_b     = stc_pkg::MulBW'(tol_high_ff);
         end
         stc_pkg::ST_HIGH: begin
            mul_start = mul_done && !in_band;
            mul_a     = stc_pkg::MulAW'(d_ff);
            mul_b     = k_sel;
         end
         stc_pkg::ST_DK: begin
            mul_start = mul_done;
            mul_a     = up_ff ? stc_pkg::APos : stc_pkg::ANeg;
            mul_b     = stc_pkg::MulBW'(m_next);
         end
         stc_pkg::ST_UM_GO: begin
            mul_start = 1'b1;
            mul_a     = u_mag[stc_pkg::MulAW-1:0];
            mul_b     = stc_pkg::MulBW'(m_ff);
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // ---------------------------------------------------------------------------
   // control state: registers, directions, output valid
   // ---------------------------------------------------------------------------
   always_comb begin
      tol_high_in   = tol_high_ff;
      tol_low_in    = tol_low_ff;
      last_dir_in   = last_dir_ff;
      pend_dir_in   = pend_dir_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;

      if (csr_wr_en) begin
         unique case (csr_index)
            stc_pkg::CsrTolHigh: tol_high_in = csr_wdata;
            stc_pkg::CsrTolLow:  tol_low_in  = csr_wdata;
            default:             tol_high_in = tol_high_ff;
         endcase
      end

      // a successful report adopts whatever direction is pending
      if (req_xfer && (req_kind == stc_pkg::ReqReport) && req_ok) begin
         last_dir_in = pend_dir_ff;
      end

      if (state_ff == stc_pkg::ST_CLAMP) begin
         pend_dir_in = up_ff ? stc_pkg::DirPos : stc_pkg::DirNeg;
      end

      if ((state_ff == stc_pkg::ST_EMIT) && out_free) begin
         rsp_tvalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= stc_pkg::ST_IDLE;
         tol_high_ff   <= stc_pkg::RatioW'(65574);
         tol_low_ff    <= stc_pkg::RatioW'(65498);
         last_dir_ff   <= stc_pkg::DirNone;
         pend_dir_ff   <= stc_pkg::DirNone;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tol_high_ff   <= tol_high_in;
         tol_low_ff    <= tol_low_in;
         last_dir_ff   <= last_dir_in;
         pend_dir_ff   <= pend_dir_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // ---------------------------------------------------------------------------
   // payload: working registers and result
   // ---------------------------------------------------------------------------
   always_comb begin
      tf_in         = tf_ff;
      cf_in         = cf_ff;
      d_in          = d_ff;
      up_in         = up_ff;
      low_ok_in     = low_ok_ff;
      m_in          = m_ff;
      u_in          = u_ff;
      w_in          = w_ff;
      r_in          = r_ff;
      res_status_in = res_status_ff;
      res_vel_in    = res_vel_ff;
      rsp_status_in = rsp_status_ff;
      rsp_vel_in    = rsp_vel_ff;

      unique case (state_ff)
         stc_pkg::ST_IDLE: begin
            tf_in = req_tf;
            cf_in = req_cf;
            up_in = req_tf > req_cf;
            d_in  = (req_tf > req_cf) ? (req_tf - req_cf) : (req_cf - req_tf);
            res_status_in = req_ok ? stc_pkg::StatRecorded : stc_pkg::StatFailed;
            res_vel_in    = '0;
         end
         stc_pkg::ST_LOW: begin
            if (mul_done) low_ok_in = scaled > mul_prod[stc_pkg::BandW-1:0];
         end
         stc_pkg::ST_HIGH: begin
            res_status_in = stc_pkg::StatInTarget;
            res_vel_in    = '0;
         end
         stc_pkg::ST_DK: begin
            if (mul_done) m_in = m_next;
         end
         stc_pkg::ST_AM: begin
            // A*m stays below 2^39, so its low bits are the whole product
            if (mul_done) u_in = mul_prod[stc_pkg::UW-1:0] - b_q;
         end
         stc_pkg::ST_UM: begin
            if (mul_done) w_in = u_ff[stc_pkg::UW-1] ? (c_q + p_q) : (c_q - p_q);
         end
         stc_pkg::ST_ROUND: begin
            r_in = rnd[stc_pkg::SW-1:stc_pkg::QSh];
         end
         stc_pkg::ST_CLAMP: begin
            res_status_in = stc_pkg::StatEngage;
            res_vel_in    = v_cl[stc_pkg::VelW-1:0];
         end
         stc_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_status_in = res_status_ff;
               rsp_vel_in    = res_vel_ff;
            end
         end
         default: begin
            r_in = r_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      tf_ff         <= tf_in;
      cf_ff         <= cf_in;
      d_ff          <= d_in;
      up_ff         <= up_in;
      low_ok_ff     <= low_ok_in;
      m_ff          <= m_in;
      u_ff          <= u_in;
      w_ff          <= w_in;
      r_ff          <= r_in;
      res_status_ff <= res_status_in;
      res_vel_ff    <= res_vel_in;
      rsp_status_ff <= rsp_status_in;
      rsp_vel_ff    <= rsp_vel_in;
   end

   // ---------------------------------------------------------------------------
   // result transfer
   // ---------------------------------------------------------------------------
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {(stc_pkg::RspDataW - stc_pkg::VelW)'(0), rsp_vel_ff};

endmodule
